// ===== design/bfsrw_pkg.sv =====
// Shared constants, codes and item types for the bit field stream reader/writer.
`timescale 1ns / 1ps
package bfsrw_pkg;

   localparam int STORE_DEPTH    = 1024;
   localparam int ADDR_W         = $clog2(STORE_DEPTH);
   localparam int CUR_W          = 11;
   localparam int CFG_W          = 11;
   localparam int FIELD_MAX_BITS = 32;
   localparam int WIN_W          = FIELD_MAX_BITS + 8;

   localparam logic [CFG_W-1:0] LEN_RESET = 11'd1024;

   localparam logic [2:0] FUNC_REWIND = 3'd0;
   localparam logic [2:0] FUNC_WRITE  = 3'd1;
   localparam logic [2:0] FUNC_READ   = 3'd2;
   localparam logic [2:0] FUNC_PAD    = 3'd3;
   localparam logic [2:0] FUNC_SKIP   = 3'd4;
   localparam logic [2:0] FUNC_LOAD   = 3'd5;
   localparam logic [2:0] FUNC_FETCH  = 3'd6;

   typedef struct packed {
      logic [2:0]  func;
      logic [5:0]  bit_count;
      logic [31:0] write_value;
      logic [9:0]  byte_address;
      logic [7:0]  byte_data;
   } req_type;

   typedef struct packed {
      logic [31:0]      read_value;
      logic             status;
      logic [CUR_W-1:0] byte_position;
      logic [2:0]       bit_offset;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_START,
      ST_WRITE,
      ST_READ,
      ST_FINISH
   } state_type;

endpackage

// ===== design/bfsrw_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps
module bfsrw_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== design/bit_field_stream_reader_writer_top.sv =====
// Top level of the bit field stream reader/writer: cursor control and byte-serial datapath.
// The store is walked one byte per cycle through its single read port and write port, over
// the k bytes (0..5) that a field spans; a fetch byte reads a single byte.
// Items are taken one at a time; the next item is taken while a result waits.
// Reset: synchronous; cursor to byte 0 bit 0, buffer length to 1024, store contents undefined.
`timescale 1ns / 1ps
module bit_field_stream_reader_writer_top (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  bfsrw_pkg::req_type                req_data,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output bfsrw_pkg::rsp_type                rsp_data,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [bfsrw_pkg::CFG_W-1:0]       csr_data
);
   import bfsrw_pkg::*;

   state_type         state_ff, state_in;
   req_type           item_ff, item_in;
   logic [CUR_W-1:0]  cur_byte_ff, cur_byte_in;
   logic [2:0]        cur_bit_ff, cur_bit_in;
   logic [CFG_W-1:0]  len_cfg_ff, len_cfg_in;
   logic [CUR_W-1:0]  ptr_ff, ptr_in;
   logic [2:0]        cnt_ff, cnt_in;
   logic [2:0]        iss_ff, iss_in;
   logic              first_ff, first_in;
   logic [7:0]        keep_ff, keep_in;
   logic [WIN_W-1:0]  win_ff, win_in;
   logic [WIN_W-1:0]  acc_ff, acc_in;
   logic [2:0]        tail_ff, tail_in;
   logic [5:0]        nbits_ff, nbits_in;
   logic              status_ff, status_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_data_ff, rsp_data_in;

   logic              ram_we;
   logic [ADDR_W-1:0] ram_waddr;
   logic [7:0]        ram_wdata;
   logic [ADDR_W-1:0] ram_raddr;
   logic [7:0]        ram_rdata;

   logic [CUR_W-1:0]  len_eff;
   logic              is_field;
   logic              is_pad;
   logic [5:0]        fld_n;
   logic [31:0]       fld_val;
   logic [5:0]        total;
   logic [13:0]       room;
   logic              crosses;
   logic [2:0]        nbytes;
   logic [31:0]       vmsb;
   logic [WIN_W-1:0]  win_start;
   logic              skip_ok;
   logic              addr_ok;
   logic [WIN_W-1:0]  read_mask;
   logic [31:0]       read_result;
   logic              start_write;
   logic              start_read;
   logic              rsp_free;

   bfsrw_ram #(
      .WIDTH (8),
      .DEPTH (STORE_DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   assign len_eff   = (32'(len_cfg_ff) > STORE_DEPTH) ? CUR_W'(STORE_DEPTH) : len_cfg_ff;
   assign is_field  = ((item_ff.func == FUNC_WRITE) || (item_ff.func == FUNC_READ)) &&
                      (32'(item_ff.bit_count) <= FIELD_MAX_BITS);
   assign is_pad    = (item_ff.func == FUNC_PAD) && (cur_bit_ff != 3'd0);
   assign fld_n     = is_pad ? (6'd8 - {3'd0, cur_bit_ff}) : item_ff.bit_count;
   assign fld_val   = (item_ff.func == FUNC_WRITE) ? item_ff.write_value : 32'd0;
   assign total     = {3'd0, cur_bit_ff} + fld_n;
   assign room      = {len_eff - cur_byte_ff, 3'b000};
   assign crosses   = (cur_byte_ff > len_eff) || (14'(total) > room);
   assign nbytes    = 3'((7'(total) + 7'd7) >> 3);
   assign vmsb      = fld_val << (6'd32 - fld_n);
   assign win_start = {vmsb, 8'h00} >> cur_bit_ff;
   assign skip_ok   = ({1'b0, cur_byte_ff} + 12'd1) <= {1'b0, len_eff};
   assign addr_ok   = 32'(item_ff.byte_address) < STORE_DEPTH;
   assign read_mask = (WIN_W'(1) << nbits_ff) - WIN_W'(1);
   assign read_result = 32'((acc_ff >> tail_ff) & read_mask);

   assign start_write = (is_field || is_pad) && (item_ff.func != FUNC_READ) &&
                        !crosses && (fld_n != 6'd0);
   assign start_read  = (is_field && (item_ff.func == FUNC_READ) && !crosses &&
                         (fld_n != 6'd0)) || (item_ff.func == FUNC_FETCH);
   assign rsp_free    = !rsp_valid_ff || !rsp_stall;

   always_comb begin : next_state
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_START;
            end
         end
         ST_START: begin
            priority if (start_write) begin
               state_in = ST_WRITE;
            end else if (start_read) begin
               state_in = ST_READ;
            end else begin
               state_in = ST_FINISH;
            end
         end
         ST_WRITE, ST_READ: begin
            if (cnt_ff == 3'd1) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin : datapath
      item_in      = item_ff;
      cur_byte_in  = cur_byte_ff;
      cur_bit_in   = cur_bit_ff;
      len_cfg_in   = len_cfg_ff;
      ptr_in       = ptr_ff;
      cnt_in       = cnt_ff;
      iss_in       = iss_ff;
      first_in     = first_ff;
      keep_in      = keep_ff;
      win_in       = win_ff;
      acc_in       = acc_ff;
      tail_in      = tail_ff;
      nbits_in     = nbits_ff;
      status_in    = status_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      ram_we       = 1'b0;
      ram_waddr    = ADDR_W'(ptr_ff);
      ram_wdata    = win_ff[WIN_W-1 -: 8];
      ram_raddr    = ADDR_W'(ptr_ff);

      if (csr_valid) begin
         len_cfg_in = csr_data;
      end
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               item_in = req_data;
            end
         end
         ST_START: begin
            status_in = 1'b0;
            acc_in    = '0;
            first_in  = 1'b1;
            keep_in   = ~(8'hFF >> cur_bit_ff);
            win_in    = win_start;
            tail_in   = 3'd0 - total[2:0];
            nbits_in  = fld_n;
            ptr_in    = cur_byte_ff;
            ram_raddr = ADDR_W'(cur_byte_ff);
            cnt_in    = nbytes;
            iss_in    = nbytes - 3'd1;
            unique case (item_ff.func)
               FUNC_REWIND: begin
                  cur_byte_in = '0;
                  cur_bit_in  = 3'd0;
               end
               FUNC_WRITE, FUNC_READ, FUNC_PAD: begin
                  if (is_field || is_pad) begin
                     if (crosses) begin
                        cur_byte_in = len_eff;
                        cur_bit_in  = 3'd0;
                        status_in   = 1'b1;
                     end else begin
                        cur_byte_in = cur_byte_ff + CUR_W'(total[5:3]);
                        cur_bit_in  = total[2:0];
                        if (item_ff.func == FUNC_READ) begin
                           ptr_in = cur_byte_ff + CUR_W'(1);
                        end
                     end
                  end
               end
               FUNC_SKIP: begin
                  if (cur_bit_ff != 3'd0) begin
                     if (skip_ok) begin
                        cur_byte_in = cur_byte_ff + CUR_W'(1);
                        cur_bit_in  = 3'd0;
                     end else begin
                        status_in = 1'b1;
                     end
                  end
               end
               FUNC_LOAD: begin
                  ram_we    = addr_ok;
                  ram_waddr = ADDR_W'(item_ff.byte_address);
                  ram_wdata = item_ff.byte_data;
               end
               FUNC_FETCH: begin
                  ram_raddr = ADDR_W'(item_ff.byte_address);
                  cnt_in    = 3'd1;
                  iss_in    = 3'd0;
               end
               default: begin
               end
            endcase
         end
         ST_WRITE: begin
            ram_we    = 1'b1;
            ram_wdata = win_ff[WIN_W-1 -: 8] | (first_ff ? (ram_rdata & keep_ff) : 8'h00);
            ptr_in    = ptr_ff + CUR_W'(1);
            win_in    = win_ff << 8;
            first_in  = 1'b0;
            cnt_in    = cnt_ff - 3'd1;
         end
         ST_READ: begin
            acc_in = {acc_ff[WIN_W-9:0], ram_rdata};
            cnt_in = cnt_ff - 3'd1;
            if (iss_ff != 3'd0) begin
               ptr_in = ptr_ff + CUR_W'(1);
               iss_in = iss_ff - 3'd1;
            end
         end
         ST_FINISH: begin
            if (rsp_free) begin
               rsp_valid_in               = 1'b1;
               rsp_data_in.status         = status_ff;
               rsp_data_in.byte_position  = cur_byte_ff;
               rsp_data_in.bit_offset     = cur_bit_ff;
               priority if (item_ff.func == FUNC_READ) begin
                  rsp_data_in.read_value = read_result;
               end else if ((item_ff.func == FUNC_FETCH) && addr_ok) begin
                  rsp_data_in.read_value = {24'd0, acc_ff[7:0]};
               end else begin
                  rsp_data_in.read_value = 32'd0;
               end
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cur_byte_ff  <= '0;
         cur_bit_ff   <= 3'd0;
         len_cfg_ff   <= LEN_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cur_byte_ff  <= cur_byte_in;
         cur_bit_ff   <= cur_bit_in;
         len_cfg_ff   <= len_cfg_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff     <= item_in;
      ptr_ff      <= ptr_in;
      cnt_ff      <= cnt_in;
      iss_ff      <= iss_in;
      first_ff    <= first_in;
      keep_ff     <= keep_in;
      win_ff      <= win_in;
      acc_ff      <= acc_in;
      tail_ff     <= tail_in;
      nbits_ff    <= nbits_in;
      status_ff   <= status_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;
   assign csr_ready = 1'b1;

endmodule
